@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Same-cycle and next-cycle implication, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, gated by reset
`define BAK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, gated by reset
`define BAK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, also checked in reset
`define BAK_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/bak_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bak_pkg
// Types, constants and helpers of the block-averaged Kaczmarz solver.
// ---------------------------------------------------------------------------
package bak_pkg;

   localparam int ROWS        = 64;
   localparam int COLS        = 64;
   localparam int MAX_THREADS = 16;
   localparam int MAX_BLOCK   = 64;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int COL_W       = $clog2(COLS);
   localparam int CNT_W       = COL_W + 1;
   localparam int THR_W       = $clog2(MAX_THREADS) + 1;
   localparam int DATA_W      = 32;
   localparam int OPER_W      = DATA_W + 1;
   localparam int PROD_W      = 2 * OPER_W;
   localparam int FRAC        = 16;
   localparam int ACC_W       = 58;
   localparam int NORM_W      = 53;
   localparam int QUO_W       = 48;
   localparam int DCNT_W      = $clog2(QUO_W + 1);

   localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sd2147483648;

   // request modes
   localparam logic [2:0] MODE_LOAD_A   = 3'd0;
   localparam logic [2:0] MODE_LOAD_B   = 3'd1;
   localparam logic [2:0] MODE_LOAD_REF = 3'd2;
   localparam logic [2:0] MODE_CLEAR    = 3'd3;
   localparam logic [2:0] MODE_PROJECT  = 3'd4;
   localparam logic [2:0] MODE_READ     = 3'd5;

   // register indexes
   localparam logic [2:0] REG_RELAX   = 3'd0;
   localparam logic [2:0] REG_COLUMNS = 3'd1;
   localparam logic [2:0] REG_THREADS = 3'd2;
   localparam logic [2:0] REG_BLOCK   = 3'd3;
   localparam logic [2:0] REG_LIMIT   = 3'd4;

   localparam logic [14:0] RELAX_RESET   = 15'd16384;
   localparam logic [6:0]  COLUMNS_RESET = 7'd64;
   localparam logic [4:0]  THREADS_RESET = 5'd1;
   localparam logic [6:0]  BLOCK_RESET   = 7'd2;
   localparam logic [31:0] LIMIT_RESET   = 32'd0;

   typedef struct packed {
      logic [2:0]         mode;
      logic [5:0]         row_index;
      logic [5:0]         col_index;
      logic signed [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               round_done;
      logic [31:0]        error_sq;
      logic               converged;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [14:0] relaxation;
      logic [6:0]  columns_in_use;
      logic [4:0]  thread_count;
      logic [6:0]  block_length;
      logic [31:0] error_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ_WAIT,
      ST_NORM,
      ST_SNAP_EST,
      ST_SNAP_PREV,
      ST_DOT,
      ST_NUM,
      ST_DIV,
      ST_UPD,
      ST_AVG,
      ST_ERR,
      ST_RESP
   } state_type;

   function automatic logic signed [PROD_W-1:0] sext_prod(input logic signed [DATA_W-1:0] v);
      return {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < SAT_MIN) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/bak_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bak_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bak_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bak_vram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bak_vram
// Vector RAM with per-entry valid bits; an entry never written reads zero.
// ---------------------------------------------------------------------------
module bak_vram (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     we,
   input  logic [bak_pkg::COL_W-1:0] waddr,
   input  logic [bak_pkg::DATA_W-1:0] wdata,
   input  logic [bak_pkg::COL_W-1:0] raddr,
   output logic [bak_pkg::DATA_W-1:0] rdata
);
   import bak_pkg::*;

   logic [DATA_W-1:0] mem [COLS];
   logic [COLS-1:0]   valid_ff;
   logic [DATA_W-1:0] rdata_ff;
   logic              rvalid_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff  <= mem[raddr];
      rvalid_ff <= valid_ff[raddr];
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

@@ rtl/bak_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bak_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bak_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bak_pkg::QUO_W-1:0]  dividend,
   input  logic [bak_pkg::NORM_W-1:0] divisor,
   output logic                       done,
   output logic [bak_pkg::QUO_W-1:0]  quotient
);
   import bak_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [NORM_W-1:0] rem_ff;
   logic [NORM_W-1:0] div_ff;
   logic [NORM_W:0]   shifted;
   logic [NORM_W+1:0] trial;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DCNT_W'(1);
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[NORM_W+1]) begin
            rem_ff <= trial[NORM_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[NORM_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/bak_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bak_core
// Sequencer, vector stores and shared multiplier of the Kaczmarz solver.
// ---------------------------------------------------------------------------
module bak_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bak_pkg::req_type req_data,
   input  bak_pkg::cfg_type cfg,
   output logic             done,
   input  logic             take,
   output bak_pkg::rsp_type result
);
   import bak_pkg::*;

   state_type state_ff, state_in;
   req_type   req_q_ff;
   rsp_type   rsp_q_ff;

   logic [CNT_W-1:0]          j_ff;
   logic [1:0]                ph_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [NORM_W-1:0]         norm_ff;
   logic signed [DATA_W-1:0]  res_ff;
   logic signed [DATA_W-1:0]  scale_ff;
   logic                      nsign_ff;
   logic [COL_W-1:0]          proj_ff;
   logic [THR_W-2:0]          thread_ff;
   logic signed [PROD_W-1:0]  product_ff;

   logic signed [DATA_W-1:0]  a_rd, b_rd, ref_rd, est_rd, prev_rd, w_rd;
   logic [DATA_W-1:0]         a_raw, b_raw, ref_raw, est_raw, prev_raw, w_raw;

   logic                      a_we, b_we, ref_we, est_we, prev_we, w_we, vec_clear;
   logic [DATA_W-1:0]         est_wdata, w_wdata;
   logic [COL_W-1:0]          j_idx, est_raddr;
   logic signed [OPER_W-1:0]  mul_a, mul_b;
   logic                      div_start, div_done;
   logic [QUO_W-1:0]          div_dividend, quotient;
   logic [NORM_W-1:0]         div_divisor;

   logic                      last_n, last_all, entering;
   logic signed [ACC_W-1:0]   prod_ext, acc_sum;
   logic signed [OPER_W-1:0]  delta, delta_abs, diff;
   logic signed [PROD_W-1:0]  prod_abs, quo_ext, signed_q;
   logic signed [DATA_W-1:0]  est_new, w_new, res_new;
   logic [DATA_W-1:0]         err_val;
   logic [CNT_W-1:0]          proj_inc;
   logic [THR_W-1:0]          thread_inc;

   assign a_rd    = a_raw;
   assign b_rd    = b_raw;
   assign ref_rd  = ref_raw;
   assign est_rd  = est_raw;
   assign prev_rd = prev_raw;
   assign w_rd    = w_raw;

   bak_ram #(.DEPTH(ROWS * COLS), .WIDTH(DATA_W)) u_matrix (
      .clock (clock),
      .we    (a_we),
      .waddr ({req_q_ff.row_index, req_q_ff.col_index}),
      .wdata (req_q_ff.data_value),
      .raddr ({req_q_ff.row_index, j_idx}),
      .rdata (a_raw)
   );

   bak_ram #(.DEPTH(ROWS), .WIDTH(DATA_W)) u_rhs (
      .clock (clock),
      .we    (b_we),
      .waddr (req_q_ff.row_index),
      .wdata (req_q_ff.data_value),
      .raddr (req_q_ff.row_index),
      .rdata (b_raw)
   );

   bak_ram #(.DEPTH(COLS), .WIDTH(DATA_W)) u_reference (
      .clock (clock),
      .we    (ref_we),
      .waddr (req_q_ff.col_index),
      .wdata (req_q_ff.data_value),
      .raddr (j_idx),
      .rdata (ref_raw)
   );

   bak_vram u_estimate (
      .clock (clock), .reset (reset), .clear (vec_clear), .we (est_we),
      .waddr (j_idx), .wdata (est_wdata), .raddr (est_raddr), .rdata (est_raw)
   );

   bak_vram u_previous (
      .clock (clock), .reset (reset), .clear (vec_clear), .we (prev_we),
      .waddr (j_idx), .wdata (est_raw), .raddr (j_idx), .rdata (prev_raw)
   );

   bak_vram u_work (
      .clock (clock), .reset (reset), .clear (vec_clear), .we (w_we),
      .waddr (j_idx), .wdata (w_wdata), .raddr (j_idx), .rdata (w_raw)
   );

   bak_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // datapath terms
   assign j_idx      = j_ff[COL_W-1:0];
   assign last_n     = (j_ff + CNT_W'(1)) == cfg.columns_in_use;
   assign last_all   = j_idx == COL_W'(COLS - 1);
   assign entering   = state_in != state_ff;
   assign prod_ext   = {{(ACC_W-(PROD_W-FRAC)){product_ff[PROD_W-1]}},
                        product_ff[PROD_W-1:FRAC]};
   assign acc_sum    = acc_ff + prod_ext;
   assign delta      = {w_rd[DATA_W-1], w_rd} - {prev_rd[DATA_W-1], prev_rd};
   assign delta_abs  = delta[OPER_W-1] ? -delta : delta;
   assign diff       = {est_rd[DATA_W-1], est_rd} - {ref_rd[DATA_W-1], ref_rd};
   assign prod_abs   = product_ff[PROD_W-1] ? -product_ff : product_ff;
   assign quo_ext    = {{(PROD_W-QUO_W){1'b0}}, quotient};
   assign signed_q   = nsign_ff ? -quo_ext : quo_ext;
   assign est_new    = sat32(sext_prod(est_rd) + signed_q);
   assign w_new      = sat32(sext_prod(w_rd) + {{FRAC{product_ff[PROD_W-1]}},
                                                product_ff[PROD_W-1:FRAC]});
   assign res_new    = sat32(sext_prod(b_rd) - {{(PROD_W-ACC_W){acc_sum[ACC_W-1]}}, acc_sum});
   assign err_val    = (acc_sum[ACC_W-1:DATA_W] != '0) ? '1 : acc_sum[DATA_W-1:0];
   assign proj_inc   = {1'b0, proj_ff} + CNT_W'(1);
   assign thread_inc = {1'b0, thread_ff} + THR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (req_q_ff.mode == MODE_READ) begin
               state_in = ST_READ_WAIT;
            end else if (req_q_ff.mode == MODE_PROJECT) begin
               state_in = ST_NORM;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_READ_WAIT: state_in = ST_RESP;
         ST_NORM: begin
            if (ph_ff == 2'd2 && last_n) begin
               if (acc_sum == '0) begin
                  state_in = ST_RESP;
               end else if (proj_ff != '0) begin
                  state_in = ST_DOT;
               end else if (thread_ff == '0) begin
                  state_in = ST_SNAP_EST;
               end else begin
                  state_in = ST_SNAP_PREV;
               end
            end
         end
         ST_SNAP_EST: begin
            if (ph_ff == 2'd1 && last_all) state_in = ST_SNAP_PREV;
         end
         ST_SNAP_PREV: begin
            if (ph_ff == 2'd1 && last_all) state_in = ST_DOT;
         end
         ST_DOT: begin
            if (ph_ff == 2'd2 && last_n) state_in = ST_NUM;
         end
         ST_NUM: begin
            if (ph_ff == 2'd1) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (ph_ff == 2'd2 && last_n) begin
               state_in = (proj_inc >= cfg.block_length) ? ST_AVG : ST_RESP;
            end
         end
         ST_AVG: begin
            if (ph_ff == 2'd2 && div_done && last_n) begin
               state_in = (thread_inc >= cfg.thread_count) ? ST_ERR : ST_RESP;
            end
         end
         ST_ERR: begin
            if (ph_ff == 2'd2 && last_n) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and unit controls
   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      done         = state_ff == ST_RESP;
      a_we         = 1'b0;
      b_we         = 1'b0;
      ref_we       = 1'b0;
      est_we       = 1'b0;
      prev_we      = 1'b0;
      w_we         = 1'b0;
      vec_clear    = 1'b0;
      w_wdata      = w_new;
      est_wdata    = est_new;
      est_raddr    = j_idx;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = {prod_abs[QUO_W-3:0], 2'b00};
      div_divisor  = norm_ff;
      unique case (state_ff)
         ST_DISPATCH: begin
            est_raddr = req_q_ff.col_index;
            a_we      = req_q_ff.mode == MODE_LOAD_A;
            b_we      = req_q_ff.mode == MODE_LOAD_B;
            ref_we    = req_q_ff.mode == MODE_LOAD_REF;
            vec_clear = req_q_ff.mode == MODE_CLEAR;
         end
         ST_NORM: begin
            mul_a = {a_rd[DATA_W-1], a_rd};
            mul_b = {a_rd[DATA_W-1], a_rd};
         end
         ST_SNAP_EST:  prev_we = ph_ff == 2'd1;
         ST_SNAP_PREV: begin
            w_we    = ph_ff == 2'd1;
            w_wdata = prev_rd;
         end
         ST_DOT: begin
            mul_a = {a_rd[DATA_W-1], a_rd};
            mul_b = {w_rd[DATA_W-1], w_rd};
         end
         ST_NUM: begin
            mul_a     = {{(OPER_W-15){1'b0}}, cfg.relaxation};
            mul_b     = {res_ff[DATA_W-1], res_ff};
            div_start = ph_ff == 2'd1;
         end
         ST_UPD: begin
            mul_a = {scale_ff[DATA_W-1], scale_ff};
            mul_b = {a_rd[DATA_W-1], a_rd};
            w_we  = ph_ff == 2'd2;
         end
         ST_AVG: begin
            div_start    = ph_ff == 2'd1;
            div_dividend = {{(QUO_W-OPER_W){1'b0}}, delta_abs};
            div_divisor  = {{(NORM_W-5){1'b0}}, cfg.thread_count};
            est_we       = ph_ff == 2'd2 && div_done;
         end
         ST_ERR: begin
            mul_a = diff;
            mul_b = diff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         j_ff      <= '0;
         ph_ff     <= '0;
         proj_ff   <= '0;
         thread_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (entering) begin
            j_ff  <= '0;
            ph_ff <= '0;
         end else begin
            unique case (state_ff)
               ST_NORM, ST_DOT, ST_UPD, ST_ERR: begin
                  if (ph_ff == 2'd2) begin
                     ph_ff <= '0;
                     j_ff  <= j_ff + CNT_W'(1);
                  end else begin
                     ph_ff <= ph_ff + 2'd1;
                  end
               end
               ST_AVG: begin
                  if (ph_ff != 2'd2) begin
                     ph_ff <= ph_ff + 2'd1;
                  end else if (div_done) begin
                     ph_ff <= '0;
                     j_ff  <= j_ff + CNT_W'(1);
                  end
               end
               ST_SNAP_EST, ST_SNAP_PREV: begin
                  if (ph_ff == 2'd1) begin
                     ph_ff <= '0;
                     j_ff  <= j_ff + CNT_W'(1);
                  end else begin
                     ph_ff <= ph_ff + 2'd1;
                  end
               end
               ST_NUM: ph_ff <= ph_ff + 2'd1;
               default: begin
               end
            endcase
         end
         if (state_ff == ST_DISPATCH && req_q_ff.mode == MODE_CLEAR) begin
            proj_ff   <= '0;
            thread_ff <= '0;
         end
         if (state_ff == ST_UPD && entering) begin
            proj_ff <= (proj_inc >= cfg.block_length) ? '0 : proj_inc[COL_W-1:0];
         end
         if (state_ff == ST_AVG && entering) begin
            thread_ff <= (thread_inc >= cfg.thread_count) ? '0 : thread_inc[THR_W-2:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
      if (entering) begin
         acc_ff <= '0;
      end else if (ph_ff == 2'd2 &&
                   (state_ff == ST_NORM || state_ff == ST_DOT || state_ff == ST_ERR)) begin
         acc_ff <= acc_sum;
      end
      if (state_ff == ST_IDLE && req_valid) begin
         req_q_ff <= req_data;
         rsp_q_ff <= '0;
      end
      if (state_ff == ST_READ_WAIT) begin
         rsp_q_ff.read_value <= est_rd;
      end
      if (state_ff == ST_NORM && entering) begin
         norm_ff <= acc_sum[NORM_W-1:0];
         // drop the projection on a zero-norm row
         if (acc_sum == '0) rsp_q_ff.status <= 1'b1;
      end
      if (state_ff == ST_DOT && entering) begin
         res_ff <= res_new;
      end
      if (div_start) begin
         nsign_ff <= (state_ff == ST_AVG) ? delta[OPER_W-1] : product_ff[PROD_W-1];
      end
      if (state_ff == ST_DIV && div_done) begin
         scale_ff <= sat32(signed_q);
      end
      if (state_ff == ST_ERR && entering) begin
         rsp_q_ff.round_done <= 1'b1;
         rsp_q_ff.error_sq   <= err_val;
         rsp_q_ff.converged  <= err_val < cfg.error_limit;
      end
   end

   assign result = rsp_q_ff;

endmodule

@@ rtl/block_averaged_kaczmarz_solver_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_averaged_kaczmarz_solver_top
// Relaxed Kaczmarz projections averaged over thread blocks, Q16.16.
// ---------------------------------------------------------------------------
//  channel   handshake                    payload
//  req       req_valid / req_ready        req_data  (bak_pkg::req_type)
//  rsp       rsp_valid / rsp_ready        rsp_data  (bak_pkg::rsp_type)
//  csr       psel, penable, pwrite        paddr, pwdata, prdata, pready
//
//  A projection computes the norm, the dot product, the step division and
//  the update, plus both snapshots at a round start (one at a later block
//  start), the averaging at block end (one serial division per column) and
//  the round error. All multiplies share the single multiplier and all
//  divisions share the serial divider.
//  One request is in flight at a time; a finished response waits in the
//  output register while the next request is taken. Reset is synchronous.
// ---------------------------------------------------------------------------
module block_averaged_kaczmarz_solver_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bak_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bak_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import bak_pkg::*;

   logic [14:0] relax_ff;
   logic [6:0]  columns_ff;
   logic [4:0]  threads_ff;
   logic [6:0]  block_ff;
   logic [31:0] limit_ff;
   logic [2:0]  reg_index;
   logic        csr_write;
   cfg_type     cfg;
   logic        core_done;
   logic        take;
   rsp_type     core_result;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff   <= RELAX_RESET;
         columns_ff <= COLUMNS_RESET;
         threads_ff <= THREADS_RESET;
         block_ff   <= BLOCK_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_RELAX:   relax_ff   <= pwdata[14:0];
            REG_COLUMNS: columns_ff <= pwdata[6:0];
            REG_THREADS: threads_ff <= pwdata[4:0];
            REG_BLOCK:   block_ff   <= pwdata[6:0];
            REG_LIMIT:   limit_ff   <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_RELAX:   prdata = {17'd0, relax_ff};
         REG_COLUMNS: prdata = {25'd0, columns_ff};
         REG_THREADS: prdata = {27'd0, threads_ff};
         REG_BLOCK:   prdata = {25'd0, block_ff};
         REG_LIMIT:   prdata = limit_ff;
         default:     prdata = '0;
      endcase
   end

   // clamp the counts to their usable ranges
   always_comb begin
      cfg.relaxation  = relax_ff;
      cfg.error_limit = limit_ff;
      priority if (columns_ff == '0) cfg.columns_in_use = 7'd1;
      else if (columns_ff > 7'(COLS)) cfg.columns_in_use = 7'(COLS);
      else cfg.columns_in_use = columns_ff;
      priority if (threads_ff == '0) cfg.thread_count = 5'd1;
      else if (threads_ff > 5'(MAX_THREADS)) cfg.thread_count = 5'(MAX_THREADS);
      else cfg.thread_count = threads_ff;
      priority if (block_ff < 7'd2) cfg.block_length = 7'd2;
      else if (block_ff > 7'(MAX_BLOCK)) cfg.block_length = 7'(MAX_BLOCK);
      else cfg.block_length = block_ff;
   end

   bak_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .done      (core_done),
      .take      (take),
      .result    (core_result)
   );

   assign take = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done && take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done && take) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/bak_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bak_checker
// Port-level checks of the Kaczmarz solver, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bak_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bak_pkg::rsp_type rsp_data
);
   import bak_pkg::*;

   // one request in flight: busy right after a request is taken
   `BAK_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   `BAK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `BAK_ASSERT_SAME(a_round_fields, clock, reset, rsp_valid && !rsp_data.round_done, !rsp_data.converged && rsp_data.error_sq == '0)

   `BAK_ASSERT_SAME(a_skip_alone, clock, reset, rsp_valid && rsp_data.status, !rsp_data.round_done && rsp_data.read_value == '0)

   `BAK_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind block_averaged_kaczmarz_solver_top bak_checker u_checker (.*);
